>>> rtl/core/sobel_x_edge_filter_3x3_macros.svh
// Assertion macros used by the edge filter top level.
`ifndef SOBEL_X_EDGE_FILTER_3X3_MACROS_SVH
`define SOBEL_X_EDGE_FILTER_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS

// When the condition holds, the consequence must hold in the same cycle.
`define SOBX_ASSERT_IMPLIES(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("sobx assertion failed: same-cycle implication");

// When the condition holds, the consequence must hold in the next cycle.
`define SOBX_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("sobx assertion failed: next-cycle implication");

`else

`define SOBX_ASSERT_IMPLIES(lbl, cond, cons)
`define SOBX_ASSERT_NEXT(lbl, cond, cons)

`endif

`endif

>>> rtl/core/sobx_pkg.sv
// Shared types and constants of the Sobel x edge filter.
`default_nettype none

package sobx_pkg;

    // Pixel and configuration register widths.
    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 13;
    localparam int MAXV_W   = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // Register index codes (byte address bits 3:2).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE    = 2'd2;

    // Register reset values.
    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [MAXV_W-1:0]  RST_MAX_VALUE    = 8'd255;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Column differences of one window, plus the frame end flag.
    typedef struct packed {
        logic signed [PIX_W:0] d_top;
        logic signed [PIX_W:0] d_mid;
        logic signed [PIX_W:0] d_bot;
        logic                  last;
    } sobx_diff_t;

    // Status of the front stage, seen by the top level.
    typedef struct packed {
        logic s1_valid;
        logic s1_blocked;
    } sobx_front_status_t;

endpackage

`default_nettype wire

>>> rtl/core/sobx_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module sobx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sobx_queue.sv
// Short register queue that decouples the front and back of the filter.
`default_nettype none

module sobx_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sobx_front.sv
// Front of the filter: raster counters, line stores, window and classification.
`default_nettype none

module sobx_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [sobx_pkg::IMG_W_W-1:0]         image_width,
    input  wire logic [sobx_pkg::IMG_H_W-1:0]         image_height,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [sobx_pkg::PIX_W-1:0]           pixel,
    output logic                                      push,
    output sobx_pkg::sobx_diff_t                      push_diff,
    output logic      [$clog2(MAX_WIDTH)-1:0]         push_col,
    output logic      [$clog2(MAX_HEIGHT)-1:0]        push_row,
    input  wire logic                                 q_full,
    output sobx_pkg::sobx_front_status_t              status
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PW    = sobx_pkg::PIX_W;

    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic [COL_W-1:0] col_reg, col_next, c_cur;
    logic [ROW_W-1:0] row_reg, row_next, r_cur;
    logic [ROW_W:0]   r_wrap;
    logic [COL_W:0]   c_plus;
    logic [ROW_W:0]   r_plus;
    logic             accept;
    logic             interior;
    logic             last;

    logic             s1_valid_reg;
    logic [PW-1:0]    s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_interior_reg;
    logic             s1_last_reg;
    logic             s1_adv;

    logic [PW-1:0]    upper_rd;
    logic [PW-1:0]    middle_rd;

    // Window columns 1 and 2, rows top, middle and bottom.
    logic [PW-1:0]    win1_reg [3];
    logic [PW-1:0]    win2_reg [3];

    // Frame geometry clamped to the supported range.
    always_comb
    begin
        if (image_width < 3)
        begin
            w_eff = (COL_W+1)'(3);
        end
        else if (image_width > MAX_WIDTH)
        begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (COL_W+1)'(image_width);
        end
        if (image_height < 3)
        begin
            h_eff = (ROW_W+1)'(3);
        end
        else if (image_height > MAX_HEIGHT)
        begin
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = (ROW_W+1)'(image_height);
        end
    end

    // Position of the incoming pixel, wrapping counters left beyond a shrunk frame.
    always_comb
    begin
        r_wrap = {1'b0, row_reg};
        c_cur  = col_reg;
        if ({1'b0, col_reg} >= w_eff)
        begin
            c_cur  = '0;
            r_wrap = {1'b0, row_reg} + 1'b1;
        end
        r_cur = (r_wrap >= h_eff) ? '0 : r_wrap[ROW_W-1:0];
    end

    // Counter values after this pixel.
    always_comb
    begin
        c_plus   = {1'b0, c_cur} + 1'b1;
        r_plus   = {1'b0, r_cur} + 1'b1;
        col_next = c_plus[COL_W-1:0];
        row_next = r_cur;
        if (c_plus >= w_eff)
        begin
            col_next = '0;
            row_next = (r_plus >= h_eff) ? '0 : r_plus[ROW_W-1:0];
        end
    end

    // Classification: interior center and frame end.
    assign interior = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    assign last     = ({1'b0, r_cur} == h_eff - 1'b1) && ({1'b0, c_cur} == w_eff - 1'b1);

    // Handshake: the stage holding the line store data moves on unless it holds an interior beat and the queue is full.
    assign s1_adv   = s1_valid_reg && (!s1_interior_reg || !q_full);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign status.s1_valid   = s1_valid_reg;
    assign status.s1_blocked = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload held while the line stores are read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= c_cur;
            s1_row_reg      <= r_cur;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
    end

    // Line stores: read at the new column, rewritten when the beat moves on.
    sobx_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (middle_rd),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (upper_rd)
    );

    sobx_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (middle_rd)
    );

    // Sliding window shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= win2_reg[k];
            end
            win2_reg[0] <= upper_rd;
            win2_reg[1] <= middle_rd;
            win2_reg[2] <= s1_pixel_reg;
        end
    end

    // Right column minus left column of the shifted window.
    assign push                = s1_adv && s1_interior_reg;
    assign push_diff.d_top     = $signed({1'b0, upper_rd}) - $signed({1'b0, win1_reg[0]});
    assign push_diff.d_mid     = $signed({1'b0, middle_rd}) - $signed({1'b0, win1_reg[1]});
    assign push_diff.d_bot     = $signed({1'b0, s1_pixel_reg}) - $signed({1'b0, win1_reg[2]});
    assign push_diff.last      = s1_last_reg;
    assign push_col            = s1_col_reg - 1'b1;
    assign push_row            = s1_row_reg - 1'b1;

endmodule

`default_nettype wire

>>> rtl/core/sobx_back.sv
// Back of the filter: weighted sum, clamp and output register.
`default_nettype none

module sobx_back #(
    parameter int COL_W = 10,
    parameter int ROW_W = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire sobx_pkg::sobx_diff_t          q_diff,
    input  wire logic [COL_W-1:0]              q_col,
    input  wire logic [ROW_W-1:0]              q_row,
    output logic                               pop,
    input  wire logic [sobx_pkg::MAXV_W-1:0]   max_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [sobx_pkg::PIX_W-1:0]    edge_value,
    output logic      [COL_W-1:0]              out_col,
    output logic      [ROW_W-1:0]              out_row,
    output logic                               last_of_frame
);

    localparam int SUM_W = sobx_pkg::PIX_W + 3;

    logic signed [SUM_W-1:0]         sum;
    logic        [sobx_pkg::PIX_W-1:0] clamped;
    logic                            out_valid_reg;
    logic        [sobx_pkg::PIX_W-1:0] edge_value_reg;
    logic        [COL_W-1:0]         out_col_reg;
    logic        [ROW_W-1:0]         out_row_reg;
    logic                            last_of_frame_reg;

    // Kernel rows weigh 1, 2, 1.
    assign sum = SUM_W'(q_diff.d_top) + (SUM_W'(q_diff.d_mid) <<< 1) + SUM_W'(q_diff.d_bot);

    // Clamp to zero below and the configured maximum above.
    always_comb
    begin
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > $signed({3'b000, max_value}))
        begin
            clamped = max_value;
        end
        else
        begin
            clamped = sum[sobx_pkg::PIX_W-1:0];
        end
    end

    // Take a queue entry whenever the output register is free or being drained.
    assign pop           = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid     = out_valid_reg;
    assign edge_value    = edge_value_reg;
    assign out_col       = out_col_reg;
    assign out_row       = out_row_reg;
    assign last_of_frame = last_of_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            edge_value_reg    <= clamped;
            out_col_reg       <= q_col;
            out_row_reg       <= q_row;
            last_of_frame_reg <= q_diff.last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sobel_x_edge_filter_3x3.sv
// Sobel x edge filter: one pixel per cycle sustained, including across row ends, unless a full queue stalls the input.
// Once the pixel one row below and one column right of its center is accepted, a result
// is registered in the line store read stage, then in the queue, then in the output register.
// Border centers give no result, so output beats are fewer than input beats.
// Reset clears counters, window, queue and output valid and loads 640, 480, 255;
// the line stores are not cleared; reads in a frame's first two rows never reach a result.
`default_nettype none

`include "sobel_x_edge_filter_3x3_macros.svh"

module sobel_x_edge_filter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sobx_pkg::APB_AW-1:0]         paddr,
    input  wire logic [sobx_pkg::APB_DW-1:0]         pwdata,
    output logic      [sobx_pkg::APB_DW-1:0]         prdata,
    output logic                                     pready,
    // Pixel input.
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [sobx_pkg::PIX_W-1:0]          pixel,
    // Result output.
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [sobx_pkg::PIX_W-1:0]          edge_value,
    output logic      [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic      [$clog2(MAX_HEIGHT)-1:0]       out_row,
    output logic                                     last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int QW    = $bits(sobx_pkg::sobx_diff_t) + COL_W + ROW_W;

    logic [sobx_pkg::IMG_W_W-1:0] image_width_reg;
    logic [sobx_pkg::IMG_H_W-1:0] image_height_reg;
    logic [sobx_pkg::MAXV_W-1:0]  max_value_reg;
    logic                         cfg_write;

    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic [QW-1:0]                q_din;
    logic [QW-1:0]                q_dout;
    sobx_pkg::sobx_diff_t         push_diff;
    logic [COL_W-1:0]             push_col;
    logic [ROW_W-1:0]             push_row;
    sobx_pkg::sobx_diff_t         q_diff;
    logic [COL_W-1:0]             q_col;
    logic [ROW_W-1:0]             q_row;
    sobx_pkg::sobx_front_status_t front_status;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sobx_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= sobx_pkg::RST_IMAGE_HEIGHT;
            max_value_reg    <= sobx_pkg::RST_MAX_VALUE;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                sobx_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= pwdata[sobx_pkg::IMG_W_W-1:0];
                end
                sobx_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= pwdata[sobx_pkg::IMG_H_W-1:0];
                end
                sobx_pkg::REG_MAX_VALUE:
                begin
                    max_value_reg <= pwdata[sobx_pkg::MAXV_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            sobx_pkg::REG_IMAGE_WIDTH:  prdata = sobx_pkg::APB_DW'(image_width_reg);
            sobx_pkg::REG_IMAGE_HEIGHT: prdata = sobx_pkg::APB_DW'(image_height_reg);
            sobx_pkg::REG_MAX_VALUE:    prdata = sobx_pkg::APB_DW'(max_value_reg);
            default:                    prdata = '0;
        endcase
    end

    // Front: counters, line stores and window.
    sobx_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .push         (q_push),
        .push_diff    (push_diff),
        .push_col     (push_col),
        .push_row     (push_row),
        .q_full       (q_full),
        .status       (front_status)
    );

    // Queue between front and back.
    assign q_din = {push_diff, push_col, push_row};
    assign {q_diff, q_col, q_row} = q_dout;

    sobx_queue #(
        .WIDTH (QW),
        .DEPTH (sobx_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    // Back: sum, clamp and output register.
    sobx_back #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_diff        (q_diff),
        .q_col         (q_col),
        .q_row         (q_row),
        .pop           (q_pop),
        .max_value     (max_value_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .edge_value    (edge_value),
        .out_col       (out_col),
        .out_row       (out_row),
        .last_of_frame (last_of_frame)
    );

    // The input stalls only because a held beat waits on a full queue.
    `SOBX_ASSERT_IMPLIES(a_stall_cause, in_stall, front_status.s1_blocked && q_full)
    // The queue is never written while full.
    `SOBX_ASSERT_IMPLIES(a_no_overflow, q_push, !q_full)
    // The queue is never read while empty.
    `SOBX_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_empty)
    // A popped entry always shows up as a valid output beat.
    `SOBX_ASSERT_NEXT(a_pop_to_out, q_pop, out_valid)

endmodule

`default_nettype wire

>>> sim/sobel_x_edge_tb_pkg.sv
// Result record and pixel-stream gradient predictor for the Sobel x edge filter testbench.
package sobel_x_edge_tb_pkg;

    import sobx_pkg::*;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 4096;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // One result beat as it leaves the filter.
    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } edge_result_t;

    // Tracks geometry, line stores and window, and queues the gradients they imply.
    class sobel_x_predictor;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        logic [MAXV_W-1:0]  max_reg;
        logic [PIX_W-1:0]   upper_line [MAX_COLS];
        logic [PIX_W-1:0]   middle_line [MAX_COLS];
        logic [PIX_W-1:0]   win [3][3];
        int unsigned        col_count;
        int unsigned        row_count;
        edge_result_t       pending_edges [$];
        int unsigned        mismatch_count;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            max_reg    = RST_MAX_VALUE;
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
            col_count      = 0;
            row_count      = 0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [APB_DW-1:0] value);
            case (index)
                REG_IMAGE_WIDTH:  width_reg  = value[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = value[IMG_H_W-1:0];
                REG_MAX_VALUE:    max_reg    = value[MAXV_W-1:0];
                default: ;
            endcase
        endfunction

        // Geometry as the filter uses it, with out-of-range values clamped.
        function int unsigned active_width();
            if (width_reg < 3)
                return 3;
            if (width_reg > MAX_COLS)
                return MAX_COLS;
            return width_reg;
        endfunction

        function int unsigned active_height();
            if (height_reg < 3)
                return 3;
            if (height_reg > MAX_ROWS)
                return MAX_ROWS;
            return height_reg;
        endfunction

        function int unsigned frame_pixels();
            return active_width() * active_height();
        endfunction

        // Pixels still needed to finish the current frame, after any counter wrap.
        function int unsigned pixels_to_frame_end();
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            w = active_width();
            h = active_height();
            c = col_count;
            r = row_count;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            if (r >= h)
                r = 0;
            return (h - r) * w - c;
        endfunction

        function int unsigned outstanding();
            return pending_edges.size();
        endfunction

        // Advance the window by one accepted pixel and queue any interior result.
        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            int unsigned  r;
            int           sum;
            edge_result_t res;
            w = active_width();
            h = active_height();

            // A shrunken geometry wraps the counters before the pixel is placed.
            if (col_count >= w)
            begin
                col_count = 0;
                row_count++;
            end
            if (row_count >= h)
                row_count = 0;
            c = col_count;
            r = row_count;

            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = upper_line[c];
            win[1][2] = middle_line[c];
            win[2][2] = px;
            upper_line[c]  = middle_line[c];
            middle_line[c] = px;

            // Interior center one row up and one column left of this pixel.
            if (r >= 2 && c >= 2)
            begin
                sum = int'(win[0][2]) - int'(win[0][0])
                    + 2 * (int'(win[1][2]) - int'(win[1][0]))
                    + int'(win[2][2]) - int'(win[2][0]);
                if (sum < 0)
                    sum = 0;
                if (sum > int'(max_reg))
                    sum = int'(max_reg);
                res.edge_value = PIX_W'(sum);
                res.col        = COL_W'(c - 1);
                res.row        = ROW_W'(r - 1);
                res.last       = (r == h - 1) && (c == w - 1);
                pending_edges.push_back(res);
            end

            col_count = c + 1;
            if (col_count >= w)
            begin
                col_count = 0;
                row_count = r + 1;
                if (row_count >= h)
                    row_count = 0;
            end
        endfunction

        // Compare one result beat against the oldest queued gradient.
        function void check_result(edge_result_t got);
            edge_result_t want;
            if (pending_edges.size() == 0)
            begin
                $error("unexpected result: edge_value %0d at row %0d col %0d",
                       got.edge_value, got.row, got.col);
                mismatch_count++;
                return;
            end
            want = pending_edges.pop_front();
            if (got.edge_value !== want.edge_value)
            begin
                $error("edge_value: expected %0d, got %0d", want.edge_value, got.edge_value);
                mismatch_count++;
            end
            if (got.col !== want.col)
            begin
                $error("out_col: expected %0d, got %0d", want.col, got.col);
                mismatch_count++;
            end
            if (got.row !== want.row)
            begin
                $error("out_row: expected %0d, got %0d", want.row, got.row);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

>>> sim/testbench.sv
// Top-level testbench: drives pixel frames and register writes, checks every result beat.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sobx_pkg::*;
    import sobel_x_edge_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 400;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel         = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [PIX_W-1:0]  edge_value;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              last_of_frame;

    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       cycle_count    = 0;
    sobel_x_predictor  gradient_model;

    sobel_x_edge_filter_3x3 #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .edge_value    (edge_value),
        .out_col       (out_col),
        .out_row       (out_row),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    // Receiver backpressure, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Every accepted result beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            gradient_model.check_result({edge_value, out_col, out_row, last_of_frame});
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sobel_x_edge_filter_3x3 regression: fail");
            $finish;
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 45;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 45;
            end
            default:
            begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    // Setup then access phase; the bus is left selected for a back-to-back write.
    task automatic reg_write(logic [1:0] index, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        gradient_model.write_reg(index, value);
    endtask

    task automatic configure(logic [APB_DW-1:0] width_word, logic [APB_DW-1:0] height_word,
                             logic [APB_DW-1:0] max_word);
        reg_write(REG_IMAGE_WIDTH, width_word);
        reg_write(REG_IMAGE_HEIGHT, height_word);
        reg_write(REG_MAX_VALUE, max_word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One pixel beat, preceded by a random number of idle cycles.
    task automatic send_pixel(logic [PIX_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        gradient_model.note_pixel(value);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random(int unsigned count);
        repeat (count)
            send_pixel(rand_pixel());
    endtask

    // Stop sending, let every queued gradient arrive, then let the pipeline settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (gradient_model.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned       random_sent;
        int unsigned       count;
        int unsigned       phase;
        logic [APB_DW-1:0] width_word;
        logic [APB_DW-1:0] height_word;
        logic [APB_DW-1:0] max_word;

        gradient_model = new();
        random_sent    = 0;
        phase          = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Rising step then falling step: saturates high and low at full scale.
        set_idling(IDLE_NONE);
        configure(6, 3, 255);
        repeat (3)
        begin
            send_pixel(8'd0);
            send_pixel(8'd128);
            send_pixel(8'd255);
            send_pixel(8'd128);
            send_pixel(8'd0);
            send_pixel(8'd0);
        end
        wait_drained();

        // Undersized geometry clamps to 3x3; gradient clips at a reduced maximum.
        set_idling(IDLE_BOTH);
        configure(0, 2, 100);
        repeat (3)
        begin
            send_pixel(8'd10);
            send_pixel(8'd0);
            send_pixel(8'd60);
        end
        wait_drained();

        // Full frame at the widest random geometry: fills every column later phases reach.
        set_idling(IDLE_SENDER);
        configure(16, 3, 255);
        send_random(gradient_model.pixels_to_frame_end());
        wait_drained();

        // Oversized width clamps to the maximum; part of a first row, no wrap at 16.
        set_idling(IDLE_RECEIVER);
        configure(32'h0000_07FF, 3, 255);
        send_random(40);
        wait_drained();

        // Oversized height clamps to the maximum row count; rows run well past 8.
        set_idling(IDLE_RECEIVER);
        configure(1, 32'h0000_1FFF, 200);
        send_random(60);
        wait_drained();

        // Random geometry per phase; most phases finish frames, some stop mid-frame.
        while (random_sent < RANDOM_ITEMS)
        begin
            set_idling(idle_mode_t'(phase % 4));
            phase++;
            width_word  = $urandom();
            height_word = $urandom();
            max_word    = $urandom();
            width_word[IMG_W_W-1:0] = ($urandom_range(9) == 0)
                                    ? IMG_W_W'($urandom_range(0, 2))
                                    : IMG_W_W'($urandom_range(3, 16));
            height_word[IMG_H_W-1:0] = ($urandom_range(9) == 0)
                                     ? IMG_H_W'($urandom_range(0, 2))
                                     : IMG_H_W'($urandom_range(3, 8));
            case ($urandom_range(5))
                0:       max_word[MAXV_W-1:0] = '0;
                1, 2:    max_word[MAXV_W-1:0] = '1;
                default: max_word[MAXV_W-1:0] = MAXV_W'($urandom_range(255));
            endcase
            configure(width_word, height_word, max_word);
            if ($urandom_range(3) == 0)
                count = $urandom_range(1, 30);
            else
                count = gradient_model.pixels_to_frame_end()
                      + $urandom_range(1) * gradient_model.frame_pixels();
            send_random(count);
            random_sent += count;
            wait_drained();
        end

        if (gradient_model.mismatch_count == 0)
            $display("sobel_x_edge_filter_3x3 regression: pass");
        else
            $display("sobel_x_edge_filter_3x3 regression: fail");
        $finish;
    end

endmodule
